[src/b32d_pkg.sv]
// shared types and constants for the base32 text decoder
package b32d_pkg;

   // byte counter width inside the decoder; the reported count is its low 16 bits
   localparam int COUNT_BITS = 16;
   localparam int BYTE_COUNT_BITS = 16;
   localparam int CHAR_BITS = 8;
   localparam int SYM_BITS = 5;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic [CHAR_BITS-1:0] PAD_CHAR = 8'h3d;
   localparam logic [CHAR_BITS-1:0] UPPER_FIRST = 8'h41;
   localparam logic [CHAR_BITS-1:0] UPPER_LAST = 8'h5a;
   localparam logic [CHAR_BITS-1:0] LOWER_FIRST = 8'h61;
   localparam logic [CHAR_BITS-1:0] LOWER_LAST = 8'h7a;
   localparam logic [CHAR_BITS-1:0] DIGIT_FIRST = 8'h32;
   localparam logic [CHAR_BITS-1:0] DIGIT_LAST = 8'h37;
   // '2' maps to 26, so subtracting 0x18 lands digits on 26..31
   localparam logic [CHAR_BITS-1:0] DIGIT_OFFSET = 8'h18;

   // queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

   typedef enum logic [1:0] {
      KIND_SKIP,
      KIND_DATA,
      KIND_PAD
   } sym_kind_type;

   typedef struct packed {
      sym_kind_type kind;
      logic [SYM_BITS-1:0] value;
      logic last;
   } sym_entry_type;

endpackage

[src/b32d_front.sv]
// front end: accepts characters, classifies them and filters out inert ones
module b32d_front (
   input  logic                          req_valid,
   input  logic [b32d_pkg::CHAR_BITS-1:0] req_ch,
   input  logic                          req_last,
   input  logic                          fifo_full,
   output logic                          req_stall,
   output logic                          push,
   output b32d_pkg::sym_entry_type       push_entry
);
   import b32d_pkg::*;

   logic [CHAR_BITS-1:0] upper_diff;
   logic [CHAR_BITS-1:0] lower_diff;
   logic [CHAR_BITS-1:0] digit_diff;
   logic                 keep;

   assign upper_diff = req_ch - UPPER_FIRST;
   assign lower_diff = req_ch - LOWER_FIRST;
   assign digit_diff = req_ch - DIGIT_OFFSET;

   always_comb begin
      push_entry.kind = KIND_SKIP;
      push_entry.value = '0;
      push_entry.last = req_last;
      if (req_ch == PAD_CHAR) begin
         push_entry.kind = KIND_PAD;
      end else if (req_ch inside {[UPPER_FIRST:UPPER_LAST]}) begin
         push_entry.kind = KIND_DATA;
         push_entry.value = upper_diff[SYM_BITS-1:0];
      end else if (req_ch inside {[LOWER_FIRST:LOWER_LAST]}) begin
         push_entry.kind = KIND_DATA;
         push_entry.value = lower_diff[SYM_BITS-1:0];
      end else if (req_ch inside {[DIGIT_FIRST:DIGIT_LAST]}) begin
         push_entry.kind = KIND_DATA;
         push_entry.value = digit_diff[SYM_BITS-1:0];
      end
   end

   // a skipped character only matters when it closes the text
   assign keep = (push_entry.kind != KIND_SKIP) || req_last;
   assign req_stall = fifo_full;
   assign push = req_valid && !fifo_full && keep;

endmodule

[src/b32d_fifo.sv]
// short queue of classified symbols between front and back
module b32d_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  b32d_pkg::sym_entry_type push_entry,
   output logic                    full,
   input  logic                    pop,
   output logic                    pop_valid,
   output b32d_pkg::sym_entry_type pop_entry
);
   import b32d_pkg::*;

   localparam logic [FIFO_PTR_BITS-1:0] LAST_SLOT = FIFO_PTR_BITS'(FIFO_DEPTH - 1);
   localparam logic [FIFO_PTR_BITS:0] DEPTH_COUNT = (FIFO_PTR_BITS + 1)'(FIFO_DEPTH);

   sym_entry_type             slots_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_BITS:0]    count_ff, count_in;
   logic                      do_push, do_pop;

   assign full = (count_ff == DEPTH_COUNT);
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[src/b32d_back.sv]
// back end: bit packing, padding and count state, and the result register
module b32d_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 entry_valid,
   input  b32d_pkg::sym_entry_type              entry,
   output logic                                 pop,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [b32d_pkg::CHAR_BITS-1:0]       rsp_data_byte,
   output logic                                 rsp_has_byte,
   output logic                                 rsp_end_of_text,
   output logic [b32d_pkg::BYTE_COUNT_BITS-1:0] rsp_byte_count
);
   import b32d_pkg::*;

   localparam int ACC_BITS = 2 * CHAR_BITS;

   logic [2:0]            pos_ff, pos_in;
   logic [CHAR_BITS-1:0]  partial_ff, partial_in;
   logic                  pad_ff, pad_in;
   logic [COUNT_BITS-1:0] count_ff, count_in, count_upd;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]  data_ff, data_in;
   logic                  has_ff, has_in;
   logic                  eot_ff, eot_in;
   logic [BYTE_COUNT_BITS-1:0] cnt_out_ff, cnt_out_in;

   logic                  out_free;
   logic [ACC_BITS-1:0]   acc;
   logic [3:0]            pos_sum;
   logic                  emit;
   logic [CHAR_BITS-1:0]  out_byte;
   logic                  result;
   logic [COUNT_BITS+BYTE_COUNT_BITS-1:0] count_wide;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop = entry_valid && out_free;

   // partial bits sit at the top of a 16-bit window, the new symbol right below them
   assign acc = {partial_ff, {CHAR_BITS{1'b0}}}
              | ({entry.value, {(ACC_BITS - SYM_BITS){1'b0}}} >> pos_ff);
   assign pos_sum = {1'b0, pos_ff} + 4'd5;

   always_comb begin
      pos_in = pos_ff;
      partial_in = partial_ff;
      pad_in = pad_ff;
      emit = 1'b0;
      out_byte = '0;
      if (pop && !pad_ff) begin
         case (entry.kind)
            KIND_DATA: begin
               pos_in = pos_sum[2:0];
               if (pos_sum[3]) begin
                  emit = 1'b1;
                  out_byte = acc[ACC_BITS-1:CHAR_BITS];
                  partial_in = acc[CHAR_BITS-1:0];
               end else begin
                  partial_in = acc[ACC_BITS-1:CHAR_BITS];
               end
            end
            KIND_PAD: begin
               pad_in = 1'b1;
               pos_in = '0;
               partial_in = '0;
            end
            default: begin
            end
         endcase
      end

      count_upd = (emit && (count_ff != COUNT_MAX)) ? count_ff + 1'b1 : count_ff;
      count_in = count_upd;
      result = pop && (emit || entry.last);

      // end of text returns the decoder to its idle state
      if (pop && entry.last) begin
         pos_in = '0;
         partial_in = '0;
         pad_in = 1'b0;
         count_in = '0;
      end
   end

   assign count_wide = {{BYTE_COUNT_BITS{1'b0}}, count_upd};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      data_in = data_ff;
      has_in = has_ff;
      eot_in = eot_ff;
      cnt_out_in = cnt_out_ff;
      if (out_free) begin
         rsp_valid_in = result;
         if (result) begin
            data_in = out_byte;
            has_in = emit;
            eot_in = entry.last;
            cnt_out_in = count_wide[BYTE_COUNT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         partial_ff <= '0;
         pad_ff <= 1'b0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         partial_ff <= partial_in;
         pad_ff <= pad_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      has_ff <= has_in;
      eot_ff <= eot_in;
      cnt_out_ff <= cnt_out_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data_byte = data_ff;
   assign rsp_has_byte = has_ff;
   assign rsp_end_of_text = eot_ff;
   assign rsp_byte_count = cnt_out_ff;

endmodule

[src/base32_text_decoder_core.sv]
// top level of the streaming base32 text decoder
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_ch[7:0], req_last
//  rsp      out        rsp_valid/rsp_stall   rsp_data_byte[7:0], rsp_has_byte,
//                                            rsp_end_of_text, rsp_byte_count[15:0]
//
// one character word per cycle while req_stall is low; a result passes the symbol queue, then the result register
// rate is set by the packing step in the back end
// the four-entry symbol queue absorbs short stalls on the result side
// req_stall rises only when the queue is full
// synchronous reset empties the queue and clears the decoder state
module base32_text_decoder_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [b32d_pkg::CHAR_BITS-1:0]       req_ch,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [b32d_pkg::CHAR_BITS-1:0]       rsp_data_byte,
   output logic                                 rsp_has_byte,
   output logic                                 rsp_end_of_text,
   output logic [b32d_pkg::BYTE_COUNT_BITS-1:0] rsp_byte_count
);
   import b32d_pkg::*;

   // front to queue
   logic          push;
   sym_entry_type push_entry;
   logic          fifo_full;

   // queue to back
   logic          pop;
   logic          pop_valid;
   sym_entry_type pop_entry;

   // classify each word; skipped characters that do not end the text never enter the queue
   b32d_front u_front (
      .req_valid  (req_valid),
      .req_ch     (req_ch),
      .req_last   (req_last),
      .fifo_full  (fifo_full),
      .req_stall  (req_stall),
      .push       (push),
      .push_entry (push_entry)
   );

   // decouples acceptance from result back-pressure
   b32d_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (fifo_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // packs 5-bit groups into bytes, tracks padding and the byte count
   b32d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .entry_valid     (pop_valid),
      .entry           (pop_entry),
      .pop             (pop),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_end_of_text (rsp_end_of_text),
      .rsp_byte_count  (rsp_byte_count)
   );

endmodule
